@@ sv/assert_macros.svh @@
// assertion helpers used by the cpu_alu_and_flags_top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk, off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clk, off while rst is high
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/caf_pkg.sv @@
package caf_pkg;

  // operation codes
  typedef enum logic [5:0] {
    OP_LD     = 6'd0,
    OP_INC8   = 6'd1,
    OP_INCW   = 6'd2,
    OP_DEC8   = 6'd3,
    OP_DECW   = 6'd4,
    OP_ADD8   = 6'd5,
    OP_ADC    = 6'd6,
    OP_ADDW   = 6'd7,
    OP_ADD_SP = 6'd8,
    OP_SUB    = 6'd9,
    OP_CP     = 6'd10,
    OP_SBC    = 6'd11,
    OP_DAA    = 6'd12,
    OP_RLA    = 6'd13,
    OP_RLCA   = 6'd14,
    OP_RRA    = 6'd15,
    OP_RRCA   = 6'd16,
    OP_RL     = 6'd17,
    OP_RLC    = 6'd18,
    OP_RR     = 6'd19,
    OP_RRC    = 6'd20,
    OP_SLA    = 6'd21,
    OP_SRA    = 6'd22,
    OP_SWAP   = 6'd23,
    OP_SRL    = 6'd24,
    OP_BIT    = 6'd25,
    OP_RES    = 6'd26,
    OP_SET    = 6'd27,
    OP_CPL    = 6'd28,
    OP_AND    = 6'd29,
    OP_XOR    = 6'd30,
    OP_OR     = 6'd31,
    OP_SCF    = 6'd32,
    OP_CCF    = 6'd33,
    OP_BRANCH = 6'd34,
    OP_NOP    = 6'd35
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    CC_UNCOND = 3'd0,
    CC_C      = 3'd1,
    CC_NC     = 3'd2,
    CC_Z      = 3'd3,
    CC_NZ     = 3'd4
  } cond_t;

  // flag nibble positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [5:0]  req_type;
    logic [15:0] dst_value;
    logic [15:0] src_value;
    logic [7:0]  acc_in;
    logic [3:0]  flags_in;
    logic [15:0] stack_pointer;
    logic [2:0]  bit_index;
    logic [2:0]  condition;
  } req_t;

  typedef struct packed {
    logic [15:0] dst_result;
    logic [7:0]  acc_out;
    logic [3:0]  flags_out;
    logic        branch_taken;
  } rsp_t;

endpackage

@@ sv/caf_alu.sv @@
module caf_alu (
  input  caf_pkg::req_t req,
  output caf_pkg::rsp_t rsp
);

  logic [7:0]  d8;
  logic [7:0]  s8;
  logic [7:0]  a;
  logic [3:0]  f;
  logic        cin;
  logic        add_cin;
  logic [8:0]  add9;
  logic [4:0]  addh5;
  logic [16:0] add17;
  logic [12:0] addh13;
  logic [8:0]  sp9;
  logic [4:0]  sph5;
  logic [15:0] sp_sum;
  logic [8:0]  sub9;
  logic [4:0]  subh5;
  logic [8:0]  sbc9;
  logic [4:0]  sbch5;
  logic [8:0]  inc9;
  logic [7:0]  dec8;
  logic [7:0]  mask;
  logic [8:0]  daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_val;
  logic [7:0]  sh;
  logic        sh_co;
  logic [15:0] r;
  logic [7:0]  an;
  logic [3:0]  fn;
  logic        taken;

  assign d8  = req.dst_value[7:0];
  assign s8  = req.src_value[7:0];
  assign a   = req.acc_in;
  assign f   = req.flags_in;
  assign cin = f[caf_pkg::FLAG_C];

  assign add_cin = (caf_pkg::op_t'(req.req_type) == caf_pkg::OP_ADC) ? cin : 1'b0;
  assign add9    = {1'b0, d8} + {1'b0, s8} + {8'b0, add_cin};
  assign addh5   = {1'b0, d8[3:0]} + {1'b0, s8[3:0]} + {4'b0, add_cin};
  assign add17   = {1'b0, req.dst_value} + {1'b0, req.src_value};
  assign addh13  = {1'b0, req.dst_value[11:0]} + {1'b0, req.src_value[11:0]};
  assign sp9     = {1'b0, req.stack_pointer[7:0]} + {1'b0, s8};
  assign sph5    = {1'b0, req.stack_pointer[3:0]} + {1'b0, s8[3:0]};
  assign sp_sum  = req.stack_pointer + {{8{s8[7]}}, s8};
  assign sub9    = {1'b0, a} - {1'b0, s8};
  assign subh5   = {1'b0, a[3:0]} - {1'b0, s8[3:0]};
  assign sbc9    = {1'b0, d8} - {1'b0, s8} - {8'b0, cin};
  assign sbch5   = {1'b0, d8[3:0]} - {1'b0, s8[3:0]} - {4'b0, cin};
  assign inc9    = {1'b0, d8} + 9'd1;
  assign dec8    = d8 - 8'd1;
  assign mask    = 8'd1 << req.bit_index;

  // decimal adjust, add direction: low digit first, then high digit on the adjusted value
  assign daa_lo = {1'b0, a} + (((a[3:0] >= 4'hA) || f[caf_pkg::FLAG_H]) ? 9'h006 : 9'h000);
  assign daa_hi = (daa_lo >= 9'h0A0) || f[caf_pkg::FLAG_C];

  always_comb begin
    daa_val = a;
    if (f[caf_pkg::FLAG_N]) begin
      daa_val = a - (f[caf_pkg::FLAG_H] ? 8'h06 : 8'h00) - (f[caf_pkg::FLAG_C] ? 8'h60 : 8'h00);
    end else begin
      daa_val = daa_lo[7:0] + (daa_hi ? 8'h60 : 8'h00);
    end
  end

  // cb-prefix shifter
  always_comb begin
    case (caf_pkg::op_t'(req.req_type))
      caf_pkg::OP_RL: begin
        sh = {d8[6:0], cin};
        sh_co = d8[7];
      end
      caf_pkg::OP_RLC: begin
        sh = {d8[6:0], d8[7]};
        sh_co = d8[7];
      end
      caf_pkg::OP_RR: begin
        sh = {cin, d8[7:1]};
        sh_co = d8[0];
      end
      caf_pkg::OP_RRC: begin
        sh = {d8[0], d8[7:1]};
        sh_co = d8[0];
      end
      caf_pkg::OP_SLA: begin
        sh = {d8[6:0], 1'b0};
        sh_co = d8[7];
      end
      caf_pkg::OP_SRA: begin
        sh = {d8[7], d8[7:1]};
        sh_co = d8[0];
      end
      caf_pkg::OP_SWAP: begin
        sh = {d8[3:0], d8[7:4]};
        sh_co = 1'b0;
      end
      default: begin
        sh = {1'b0, d8[7:1]};
        sh_co = d8[0];
      end
    endcase
  end

  always_comb begin
    r     = req.dst_value;
    an    = a;
    fn    = f;
    taken = 1'b0;
    case (caf_pkg::op_t'(req.req_type))
      caf_pkg::OP_LD: r = req.src_value;
      caf_pkg::OP_INC8: begin
        r = {8'b0, inc9[7:0]};
        fn[caf_pkg::FLAG_Z] = (inc9[7:0] == 8'd0);
        fn[caf_pkg::FLAG_N] = 1'b0;
        fn[caf_pkg::FLAG_H] = (inc9[7:4] != d8[7:4]);
      end
      caf_pkg::OP_INCW: r = req.dst_value + 16'd1;
      caf_pkg::OP_DEC8: begin
        r = {8'b0, dec8};
        fn[caf_pkg::FLAG_Z] = (dec8 == 8'd0);
        fn[caf_pkg::FLAG_N] = 1'b1;
        fn[caf_pkg::FLAG_H] = (dec8[7:4] != d8[7:4]);
      end
      caf_pkg::OP_DECW: r = req.dst_value - 16'd1;
      caf_pkg::OP_ADD8, caf_pkg::OP_ADC: begin
        r = {8'b0, add9[7:0]};
        fn = {(add9[7:0] == 8'd0), 1'b0, addh5[4], add9[8]};
      end
      caf_pkg::OP_ADDW: begin
        r = add17[15:0];
        fn[caf_pkg::FLAG_N] = 1'b0;
        fn[caf_pkg::FLAG_H] = addh13[12];
        fn[caf_pkg::FLAG_C] = add17[16];
      end
      caf_pkg::OP_ADD_SP: begin
        r  = sp_sum;
        fn = {1'b0, 1'b0, sph5[4], sp9[8]};
      end
      caf_pkg::OP_SUB, caf_pkg::OP_CP: begin
        fn = {(sub9[7:0] == 8'd0), 1'b1, subh5[4], sub9[8]};
        if (caf_pkg::op_t'(req.req_type) == caf_pkg::OP_SUB) begin
          an = sub9[7:0];
        end
      end
      caf_pkg::OP_SBC: begin
        r  = {8'b0, sbc9[7:0]};
        fn = {(sbc9[7:0] == 8'd0), 1'b1, sbch5[4], sbc9[8]};
      end
      caf_pkg::OP_DAA: begin
        an = daa_val;
        fn[caf_pkg::FLAG_Z] = (daa_val == 8'd0);
        fn[caf_pkg::FLAG_H] = 1'b0;
        if (!f[caf_pkg::FLAG_N] && daa_hi) begin
          fn[caf_pkg::FLAG_C] = 1'b1;
        end
      end
      caf_pkg::OP_RLA: begin
        an = {a[6:0], cin};
        fn = {3'b000, a[7]};
      end
      caf_pkg::OP_RLCA: begin
        an = {a[6:0], a[7]};
        fn = {3'b000, a[7]};
      end
      caf_pkg::OP_RRA: begin
        an = {cin, a[7:1]};
        fn = {3'b000, a[0]};
      end
      caf_pkg::OP_RRCA: begin
        an = {a[0], a[7:1]};
        fn = {3'b000, a[0]};
      end
      caf_pkg::OP_RL, caf_pkg::OP_RLC, caf_pkg::OP_RR, caf_pkg::OP_RRC,
      caf_pkg::OP_SLA, caf_pkg::OP_SRA, caf_pkg::OP_SWAP, caf_pkg::OP_SRL: begin
        r  = {8'b0, sh};
        fn = {(sh == 8'd0), 2'b00, sh_co};
      end
      caf_pkg::OP_BIT: begin
        fn[caf_pkg::FLAG_Z] = ((d8 & mask) == 8'd0);
        fn[caf_pkg::FLAG_N] = 1'b0;
        fn[caf_pkg::FLAG_H] = 1'b1;
      end
      caf_pkg::OP_RES: r = {8'b0, d8 & ~mask};
      caf_pkg::OP_SET: r = {8'b0, d8 | mask};
      caf_pkg::OP_CPL: begin
        an = ~a;
        fn[caf_pkg::FLAG_N] = 1'b1;
        fn[caf_pkg::FLAG_H] = 1'b1;
      end
      caf_pkg::OP_AND: begin
        an = a & s8;
        fn = {((a & s8) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      caf_pkg::OP_XOR: begin
        an = a ^ s8;
        fn = {((a ^ s8) == 8'd0), 3'b000};
      end
      caf_pkg::OP_OR: begin
        an = a | s8;
        fn = {((a | s8) == 8'd0), 3'b000};
      end
      caf_pkg::OP_SCF: fn = {f[caf_pkg::FLAG_Z], 3'b001};
      caf_pkg::OP_CCF: fn = {f[caf_pkg::FLAG_Z], 2'b00, ~cin};
      caf_pkg::OP_BRANCH: begin
        case (caf_pkg::cond_t'(req.condition))
          caf_pkg::CC_UNCOND: taken = 1'b1;
          caf_pkg::CC_C:      taken = cin;
          caf_pkg::CC_NC:     taken = ~cin;
          caf_pkg::CC_Z:      taken = f[caf_pkg::FLAG_Z];
          caf_pkg::CC_NZ:     taken = ~f[caf_pkg::FLAG_Z];
          default:            taken = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  assign rsp.dst_result   = r;
  assign rsp.acc_out      = an;
  assign rsp.flags_out    = fn;
  assign rsp.branch_taken = taken;

endmodule

@@ sv/cpu_alu_and_flags_top.sv @@
// alu and flag unit of an 8-bit handheld-console cpu. one beat is taken on every clock
// edge where start is high; busy is always low, so beats may arrive back to back with no
// gaps. each beat gives exactly one result, shown on rsp with done high for a single
// cycle, once the beat has passed the input register and then the result register
// around one pass of alu logic. the receiver cannot stall: capture rsp whenever done
// is high. the unit holds no state between beats; unknown operation codes act as nop
// and unknown branch conditions read as not taken.
`include "assert_macros.svh"

module cpu_alu_and_flags_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  caf_pkg::req_t req,
  output logic          done,
  output caf_pkg::rsp_t rsp
);

  // input stage
  logic          in_valid;
  caf_pkg::req_t in_req;

  // result stage
  logic          out_valid;
  caf_pkg::rsp_t out_rsp;

  caf_pkg::rsp_t alu_rsp;

  // never stalls: a new beat every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= start && !busy;
      out_valid <= in_valid;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= req;
    end
    if (in_valid) begin
      out_rsp <= alu_rsp;
    end
  end

  caf_alu u_alu (
    .req (in_req),
    .rsp (alu_rsp)
  );

  assign done = out_valid;
  assign rsp  = out_rsp;

  // every accepted beat comes out as a result with done high
  `ASSERT_CLK(a_beat_to_done, (start && !busy) |=> ##1 done, "accepted beat gave no result")
  // no result without an accepted beat before it
  `ASSERT_IMPL(a_done_has_beat, done, $past(start && !busy, 2), "result without a beat")
  // only the branch test can report taken
  `ASSERT_IMPL(a_taken_only_branch, done && rsp.branch_taken,
    $past(req.req_type, 2) == caf_pkg::OP_BRANCH, "branch taken on non-branch op")
  // compare leaves the accumulator alone
  `ASSERT_IMPL(a_cp_keeps_acc, done && ($past(req.req_type, 2) == caf_pkg::OP_CP),
    rsp.acc_out == $past(req.acc_in, 2), "compare changed the accumulator")

endmodule
